// ===== hw/rtl/lie_pkg.sv =====
// Package: shared constants and command/status types for the Lagrange evaluator.
`timescale 1ns / 1ps
package lie_pkg;
  localparam int MAX_POINTS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  typedef struct packed {
    logic clr;
    logic load_term;
    logic cmp_dup;
    logic div_start;
    logic mul_step;
    logic acc_add;
  } lie_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic dup;
  } lie_sts_t;
endpackage

// ===== hw/rtl/lie_datapath.sv =====
// Datapath: node memories, shared serial divider, serial multiplier, accumulator.
`timescale 1ns / 1ps
module lie_datapath #(
  parameter int MAX_POINTS = lie_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS = lie_pkg::FRAC_BITS_DEF,
  parameter int IW = $clog2(MAX_POINTS)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  logic [3:0] wr_idx,
  input  logic signed [31:0] wr_x,
  input  logic signed [31:0] wr_y,
  input  logic signed [31:0] qx,
  input  logic [IW-1:0] k_idx,
  input  logic [IW-1:0] j_idx,
  input  lie_pkg::lie_cmd_t cmd,
  output lie_pkg::lie_sts_t sts,
  output logic signed [31:0] sum_out,
  output logic ovf_out
);
  import lie_pkg::*;
  localparam int DW = 33 + FRAC_BITS;
  localparam int DCW = $clog2(DW + 1);
  localparam int MCW = 6;
  localparam int WW = (IW > 4) ? IW : 4;

  logic signed [31:0] xm [MAX_POINTS];
  logic signed [31:0] ym [MAX_POINTS];
  logic signed [31:0] xk_r, xj_r, yk_r;
  logic [WW-1:0] wr_top;
  assign wr_top = WW'(wr_idx);

  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_top) < 32'(MAX_POINTS))) begin
      xm[wr_top[IW-1:0]] <= wr_x;
      ym[wr_top[IW-1:0]] <= wr_y;
    end
    xk_r <= xm[k_idx];
    yk_r <= ym[k_idx];
    xj_r <= xm[j_idx];
  end

  // restoring divider on magnitudes
  logic [DW-1:0] quo_r, quo_nxt, rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic dneg_r, dneg_nxt, dbusy_r, dbusy_nxt, ddone_r, ddone_nxt;
  logic signed [32:0] num, den;
  logic [DW-1:0] trial;
  assign num = 33'(qx) - 33'(xj_r);
  assign den = 33'(xk_r) - 33'(xj_r);
  assign trial = {rem_r[DW-2:0], quo_r[DW-1]};

  always_comb begin
    quo_nxt = quo_r; rem_nxt = rem_r; dvs_nxt = dvs_r; dcnt_nxt = dcnt_r;
    dneg_nxt = dneg_r; dbusy_nxt = dbusy_r; ddone_nxt = 1'b0;
    if (cmd.div_start) begin
      quo_nxt = DW'(num[32] ? -num : num) << FRAC_BITS;
      dvs_nxt = DW'(den[32] ? -den : den);
      rem_nxt = '0;
      dneg_nxt = num[32] ^ den[32];
      dcnt_nxt = DCW'(DW);
      dbusy_nxt = 1'b1;
    end else if (dbusy_r) begin
      if (trial >= dvs_r) begin
        rem_nxt = trial - dvs_r;
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      dcnt_nxt = dcnt_r - 1'b1;
      if (dcnt_r == DCW'(1)) begin
        dbusy_nxt = 1'b0;
        ddone_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      ddone_r <= 1'b0;
    end else begin
      dbusy_r <= dbusy_nxt;
      ddone_r <= ddone_nxt;
    end
    quo_r <= quo_nxt; rem_r <= rem_nxt; dvs_r <= dvs_nxt;
    dcnt_r <= dcnt_nxt; dneg_r <= dneg_nxt;
  end

  // ratio saturation
  logic [DW:0] qmag;
  logic signed [DW:0] qs;
  logic signed [31:0] ratio;
  logic rsat;
  assign qmag = {1'b0, quo_r};
  assign qs = dneg_r ? -$signed(qmag) : $signed(qmag);
  always_comb begin
    rsat = 1'b0; ratio = qs[31:0];
    if (qs > $signed((DW+1)'(32'sh7fffffff))) begin
      ratio = 32'sh7fffffff; rsat = 1'b1;
    end else if (qs < -$signed((DW+1)'(33'sh080000000))) begin
      ratio = 32'sh80000000; rsat = 1'b1;
    end
  end

  // term multiply: 32x32 over two 32x16 partial products
  logic signed [31:0] term_r, sum_r;
  logic signed [31:0] rat_r;
  logic signed [63:0] prod_r;
  logic [1:0] mph_r;
  logic mdone_r, ovf_r;
  logic signed [48:0] pp;
  logic signed [63:0] pfull, pq;
  logic signed [31:0] tsat;
  logic tsv;
  assign pp = (mph_r == 2'd1) ? 49'(term_r) * $signed({1'b0, rat_r[15:0]})
                              : 49'(term_r) * 49'($signed(rat_r[31:16]));
  assign pfull = prod_r;
  assign pq = (pfull < 0) ? -((-pfull) >>> FRAC_BITS) : (pfull >>> FRAC_BITS);
  always_comb begin
    tsv = 1'b0; tsat = pq[31:0];
    if (pq > 64'sh7fffffff) begin tsat = 32'sh7fffffff; tsv = 1'b1; end
    else if (pq < -64'sh80000000) begin tsat = 32'sh80000000; tsv = 1'b1; end
  end
  logic signed [32:0] s33;
  assign s33 = 33'(sum_r) + 33'(term_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mph_r <= 2'd0; mdone_r <= 1'b0; ovf_r <= 1'b0;
    end else begin
      mdone_r <= 1'b0;
      if (cmd.clr) ovf_r <= 1'b0;
      if (ddone_r && rsat) ovf_r <= 1'b1;
      if (cmd.mul_step) mph_r <= 2'd1;
      else if (mph_r == 2'd1) mph_r <= 2'd2;
      else if (mph_r == 2'd2) mph_r <= 2'd3;
      else if (mph_r == 2'd3) begin
        mph_r <= 2'd0; mdone_r <= 1'b1;
        if (tsv) ovf_r <= 1'b1;
      end
      if (cmd.acc_add && (s33 > 33'sh07fffffff || s33 < -33'sh080000000)) ovf_r <= 1'b1;
    end
    if (ddone_r) rat_r <= ratio;
    if (mph_r == 2'd1) prod_r <= 64'(pp);
    if (mph_r == 2'd2) prod_r <= prod_r + (64'(pp) <<< 16);
    if (mph_r == 2'd3) term_r <= tsat;
    if (cmd.load_term) term_r <= yk_r;
    if (cmd.clr) sum_r <= '0;
    if (cmd.acc_add) begin
      if (s33 > 33'sh07fffffff) sum_r <= 32'sh7fffffff;
      else if (s33 < -33'sh080000000) sum_r <= 32'sh80000000;
      else sum_r <= s33[31:0];
    end
  end

  assign sts.div_done = ddone_r;
  assign sts.mul_done = mdone_r;
  assign sts.dup = cmd.cmp_dup && (xk_r == xj_r);
  assign sum_out = sum_r;
  assign ovf_out = ovf_r;
endmodule

// ===== hw/rtl/lie_ctrl.sv =====
// Controller: sequences duplicate check, ratio divisions and term products.
`timescale 1ns / 1ps
module lie_ctrl #(
  parameter int MAX_POINTS = lie_pkg::MAX_POINTS_DEF,
  parameter int IW = $clog2(MAX_POINTS)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [4:0] count,
  input  lie_pkg::lie_sts_t sts,
  output lie_pkg::lie_cmd_t cmd,
  output logic [IW-1:0] k_idx,
  output logic [IW-1:0] j_idx,
  output logic busy,
  output logic done,
  output logic dup_err
);
  import lie_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_DRD = 4'd1, S_DCMP = 4'd2, S_TRD = 4'd3,
                         S_TLD = 4'd4, S_JRD = 4'd5, S_DIV = 4'd6, S_DWT = 4'd7,
                         S_MWT = 4'd8, S_ADD = 4'd9, S_DONE = 4'd10, S_JNX = 4'd11;
  localparam int CW = IW + 1;
  logic [3:0] st_r, st_nxt;
  logic [CW-1:0] k_r, k_nxt, j_r, j_nxt, n_r, n_nxt;
  logic dup_r, dup_nxt;
  logic [CW-1:0] ncap;
  assign ncap = ({27'd0, count} > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(count);

  always_comb begin
    st_nxt = st_r; k_nxt = k_r; j_nxt = j_r; n_nxt = n_r; dup_nxt = dup_r;
    cmd = '0;
    case (st_r)
      S_IDLE: if (start) begin
        n_nxt = ncap; k_nxt = '0; j_nxt = '0; dup_nxt = 1'b0; cmd.clr = 1'b1;
        st_nxt = (ncap == '0) ? S_DONE : S_DRD;
      end
      S_DRD: st_nxt = S_DCMP;
      S_DCMP: begin
        cmd.cmp_dup = (j_r != k_r);
        if (sts.dup) begin dup_nxt = 1'b1; st_nxt = S_DONE; end
        else if (j_r + 1'b1 < n_r) begin j_nxt = j_r + 1'b1; st_nxt = S_DRD; end
        else if (k_r + 1'b1 < n_r) begin
          k_nxt = k_r + 1'b1; j_nxt = '0; st_nxt = S_DRD;
        end else begin k_nxt = '0; j_nxt = '0; st_nxt = S_TRD; end
      end
      S_TRD: st_nxt = S_TLD;
      S_TLD: begin cmd.load_term = 1'b1; st_nxt = S_JNX; end
      S_JNX: begin
        if (j_r == k_r) begin
          if (j_r + 1'b1 < n_r) j_nxt = j_r + 1'b1;
          else st_nxt = S_ADD;
        end else st_nxt = S_JRD;
      end
      S_JRD: st_nxt = S_DIV;
      S_DIV: begin cmd.div_start = 1'b1; st_nxt = S_DWT; end
      S_DWT: if (sts.div_done) begin cmd.mul_step = 1'b1; st_nxt = S_MWT; end
      S_MWT: if (sts.mul_done) begin
        if (j_r + 1'b1 < n_r) begin j_nxt = j_r + 1'b1; st_nxt = S_JNX; end
        else st_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.acc_add = 1'b1; j_nxt = '0;
        if (k_r + 1'b1 < n_r) begin k_nxt = k_r + 1'b1; st_nxt = S_TRD; end
        else st_nxt = S_DONE;
      end
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; k_r <= '0; j_r <= '0; n_r <= '0; dup_r <= 1'b0;
    end else begin
      st_r <= st_nxt; k_r <= k_nxt; j_r <= j_nxt; n_r <= n_nxt; dup_r <= dup_nxt;
    end
  end

  assign k_idx = k_r[IW-1:0];
  assign j_idx = j_r[IW-1:0];
  assign busy = (st_r != S_IDLE);
  assign done = (st_r == S_DONE);
  assign dup_err = dup_r;
endmodule

// ===== hw/rtl/lagrange_interpolation_evaluator.sv =====
// Top level: stream wrapper around the Lagrange evaluator controller and datapath.
// channel | dir | tdata fields (low bit up)                     | tuser
// in_     | in  | node_index[3:0] point_x point_y query_x (100b) | opcode
// out_    | out | value[31:0] status[33:32] (40b)                | -
// cfg_    | in  | point_count[4:0]                              | -
// Load words do not make the evaluator busy. An evaluate runs the serial divider
// (49 steps at Q16.16) once for each of the n*(n-1) ratios of n nodes.
// Reset is synchronous; input is held off while an evaluate runs or a
// result waits in the output register.
`timescale 1ns / 1ps
module lagrange_interpolation_evaluator #(
  parameter int MAX_POINTS = lie_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS = lie_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [103:0] in_tdata, // node_index, point_x, point_y, query_x
  input  logic in_tuser,         // opcode
  output logic out_tvalid,
  input  logic out_tready,
  output logic [39:0] out_tdata, // value, status
  input  logic cfg_we,
  input  logic [4:0] cfg_wdata
);
  import lie_pkg::*;
  localparam int IW = $clog2(MAX_POINTS);
  logic [4:0] cnt_r;
  logic signed [31:0] qx_r;
  logic ov_r;
  logic [33:0] res_r;
  lie_cmd_t cmd;
  lie_sts_t sts;
  logic [IW-1:0] k_idx, j_idx;
  logic busy, done, dup_err, ovf;
  logic signed [31:0] sum;
  logic acc, wr_en, start;

  assign in_tready = !busy && !ov_r;
  assign acc = in_tvalid && in_tready;
  assign wr_en = acc && !in_tuser;
  assign start = acc && in_tuser;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      if (cfg_we) cnt_r <= cfg_wdata;
      if (out_tvalid && out_tready) ov_r <= 1'b0;
      if (done) ov_r <= 1'b1;
    end
    if (start) qx_r <= in_tdata[99:68];
    if (done) res_r <= dup_err ? {ST_DUP, 32'd0} : {(ovf ? ST_OVF : ST_OK), sum};
  end

  lie_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk, .rst_n, .start, .count(cnt_r), .sts, .cmd, .k_idx, .j_idx,
    .busy, .done, .dup_err
  );

  lie_datapath #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .wr_en, .wr_idx(in_tdata[3:0]), .wr_x(in_tdata[35:4]),
    .wr_y(in_tdata[67:36]), .qx(qx_r), .k_idx, .j_idx, .cmd, .sts,
    .sum_out(sum), .ovf_out(ovf)
  );

  assign out_tvalid = ov_r;
  assign out_tdata = {6'd0, res_r};
endmodule

// ===== hw/rtl/lie_checker.sv =====
// Checker: port-level properties of the Lagrange evaluator, bound to the top level.
`timescale 1ns / 1ps
module lie_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [39:0] out_tdata
);
  a_noacc_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken with result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[33:32] != 2'd3) else $error("bad status");
  a_dupzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33:32] == 2'd1 |-> out_tdata[31:0] == 32'd0)
    else $error("dup nonzero");
endmodule

bind lagrange_interpolation_evaluator lie_checker u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata
);

// ===== dv/tb_checker.sv =====
// Checker: watches the evaluator's word channels, predicts results and compares them.
`timescale 1ns / 1ps
module tb_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [103:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [39:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata,
  output int           fail_count,
  output int           pending,
  output int           n_results
);
  import lie_pkg::*;
  localparam int NPTS = MAX_POINTS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam logic OP_EVAL = 1'b1;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } interp_res_t;

  logic [31:0] tab_x [NPTS];
  logic [31:0] tab_y [NPTS];
  logic [4:0]  npts_cfg;
  interp_res_t interp_q[$];
  int mism;

  function automatic longint clamp32(input longint v, inout bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic interp_res_t interp_eval(input logic [31:0] qx);
    interp_res_t r;
    int n;
    bit ovf;
    longint sum, term, xk, xj, num, den, ratio, x;
    n = (npts_cfg > NPTS) ? NPTS : npts_cfg;
    ovf = 0;
    sum = 0;
    x = longint'(signed'(qx));
    for (int k = 0; k < n; k++)
      for (int j = 0; j < n; j++)
        if (j != k && tab_x[j] == tab_x[k]) begin
          r.value = '0;
          r.status = ST_DUP;
          return r;
        end
    for (int k = 0; k < n; k++) begin
      term = longint'(signed'(tab_y[k]));
      xk = longint'(signed'(tab_x[k]));
      for (int j = 0; j < n; j++) begin
        if (j == k) continue;
        xj = longint'(signed'(tab_x[j]));
        num = x - xj;
        den = xk - xj;
        ratio = clamp32((num * (64'sd1 << FB)) / den, ovf);
        term = clamp32((term * ratio) / (64'sd1 << FB), ovf);
      end
      sum = clamp32(sum + term, ovf);
    end
    r.value = sum[31:0];
    r.status = ovf ? ST_OVF : ST_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    interp_res_t e, got;
    if (!rst_n) begin
      npts_cfg <= '0;
      fail_count <= 0;
      n_results <= 0;
      mism = 0;
      interp_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) npts_cfg <= cfg_wdata;
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_EVAL) interp_q.push_back(interp_eval(in_tdata[99:68]));
        else begin
          tab_x[in_tdata[3:0]] = in_tdata[35:4];
          tab_y[in_tdata[3:0]] = in_tdata[67:36];
        end
      end
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[31:0];
        got.status = out_tdata[33:32];
        n_results <= n_results + 1;
        if (interp_q.size() == 0) begin
          mism++;
          if (mism <= 10) $display("unexpected result word value=%h status=%0d",
                                   got.value, got.status);
        end else begin
          e = interp_q.pop_front();
          if (e.value !== got.value || e.status !== got.status) begin
            mism++;
            if (mism <= 10) $display("mismatch: exp value=%h status=%0d got value=%h status=%0d",
                                     e.value, e.status, got.value, got.status);
          end
        end
      end
      fail_count <= mism;
      pending <= interp_q.size();
    end
  end
endmodule

// ===== dv/tb_top.sv =====
// Testbench top: drives load and evaluate words into the Lagrange evaluator and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;
  localparam int WDOG_LIMIT = 200000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0, in_tuser = 0, out_tready = 0, cfg_we = 0;
  logic [103:0] in_tdata = '0;
  logic [4:0] cfg_wdata = '0;
  logic in_tready, out_tvalid;
  logic [39:0] out_tdata;
  int fail_count, pending, n_results, n_words, n_evals, idle_cycles;
  bit sending = 1;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  lagrange_interpolation_evaluator u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_wdata
  );

  tb_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_wdata,
    .fail_count, .pending, .n_results
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 8) << 16;
      3: return (-$urandom_range(1, 8)) << 16;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input logic op, input logic [3:0] idx,
                           input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] qx);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {4'b0, qx, py, px, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_words++;
    if (op == OP_EVAL) n_evals++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_count(input logic [4:0] c);
    drain();
    cfg_we <= 1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // loads slots 0..n-1 with distinct abscissae
  task automatic load_nodes(input int n, input bit wide);
    logic [31:0] base;
    base = wide ? $urandom() : ($urandom_range(0, 40) - 20) << 16;
    for (int i = 0; i < n; i++)
      send_word(OP_LOAD, i[3:0], base + (wide ? $urandom() | 1 : 32'h10000) * i,
                rand_val(), 32'h0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else out_tready <= ($urandom_range(0, 9) < 3) ? 1'b0 : 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    n_words = 0;
    n_evals = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // no nodes in use
    send_word(OP_EVAL, 0, 0, 0, 32'h7fffffff);
    // max slot load, all-ones fields
    send_word(OP_LOAD, 4'hf, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_word(OP_LOAD, 0, 32'h80000000, 32'h7fffffff, 0);
    set_count(1);
    send_word(OP_EVAL, 0, 0, 0, 32'h80000000);
    send_word(OP_LOAD, 1, 32'h7fffffff, 32'h80000000, 0);
    set_count(2);
    send_word(OP_EVAL, 0, 0, 0, 32'h0);
    send_word(OP_EVAL, 0, 0, 0, 32'h7fffffff);
    // duplicate abscissae
    send_word(OP_LOAD, 1, 32'h80000000, 32'h00010000, 0);
    send_word(OP_EVAL, 0, 0, 0, 32'h12345678);
    // near nodes with large ordinate, forcing overflow
    send_word(OP_LOAD, 0, 32'h0, 32'h7fffffff, 0);
    send_word(OP_LOAD, 1, 32'h1, 32'h80000000, 0);
    send_word(OP_EVAL, 0, 0, 0, 32'h7fff0000);
    load_nodes(16, 0);
    set_count(16);
    send_word(OP_EVAL, 0, 0, 0, 32'h00018000);
    set_count(31);
    send_word(OP_EVAL, 0, 0, 0, 32'hfffe0000);
    set_count(0);
    send_word(OP_EVAL, 0, 0, 0, 32'h1);
    while (n_words < 100) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 5);
      set_count(n[4:0]);
      load_nodes(n, $urandom_range(0, 1));
      if (n >= 2 && $urandom_range(0, 7) == 0)
        send_word(OP_LOAD, 4'($urandom_range(1, n - 1)), 32'h0, $urandom(), 0);
      if (n >= 2 && $urandom_range(0, 7) == 0)
        send_word(OP_LOAD, 0, 32'h0, $urandom(), 0);
      repeat ($urandom_range(1, 4)) send_word(OP_EVAL, 4'($urandom()), $urandom(),
                                               $urandom(), rand_val());
      if ($urandom_range(0, 3) == 0) drain();
    end
    drain();
    $display("Sent %0d words (%0d evaluations), checked %0d results,", n_words, n_evals,
             n_results);
    $display("covering node counts 0 to 31, duplicate nodes and saturation.");
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

// ===== lagrange_interpolation_evaluator.f =====
hw/rtl/lie_pkg.sv
hw/rtl/lie_datapath.sv
hw/rtl/lie_ctrl.sv
hw/rtl/lagrange_interpolation_evaluator.sv
hw/rtl/lie_checker.sv
dv/tb_checker.sv
dv/tb_top.sv
